/* rtl/core/jqd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the job queue with selectable removal order.
// No dependencies; imported by the core module (jqd_ram does not use it).
package jqd_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int TAG_BITS_DEF = 16;

	// removal order codes held in the discipline register
	localparam logic [1:0] DISC_OLDEST = 2'd0;
	localparam logic [1:0] DISC_NEWEST = 2'd1;
	localparam logic [1:0] DISC_RANDOM = 2'd2;

	localparam logic CMD_INSERT   = 1'b0;
	localparam logic CMD_RETRIEVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// what the item in flight does to the storage
	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_TAKE,
		OP_SWAP
	} op_t;

	typedef struct packed {
		logic        command;
		logic [15:0] job_tag;
		logic [3:0]  random_index;
	} item_t;

	typedef struct packed {
		logic [15:0] tag_out;
		logic        tag_valid;
		status_t     status;
		logic [4:0]  fill_count;
	} result_t;

endpackage

/* rtl/core/jqd_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// A read at the address being written returns the old contents. No dependencies.
module jqd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* rtl/core/job_queue_with_discipline_core.sv */
`timescale 1ns / 1ps
// Job queue top level: control, pointer update, bypass and result register.
// Depends on jqd_pkg and jqd_ram.
//
// Usage:
//   Command channel: drive item and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy stays low, so one
//   item may be issued every cycle.
//   Result channel: done is high for exactly one cycle with result valid;
//   every item yields one result, registered through stage 1 and then the
//   result register. Throughput is one item per cycle, set by the single
//   pass through the pointer logic and one read of the two-read-port
//   storage.
//   The receiver cannot stall: results are dropped if not taken when shown.
//   Config: APB register 0 (byte address 0) selects the removal order:
//   0 oldest first, 1 newest first, 2 random index, 3 as oldest first.
//   Write it only while no item is in flight.
//   Reset: arst_n clears the queue to empty, head to slot 0, order to oldest
//   first. Storage is not cleared; only written slots are ever read.
module job_queue_with_discipline_core #(
	parameter int DEPTH    = jqd_pkg::DEPTH_DEF,
	parameter int TAG_BITS = jqd_pkg::TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  jqd_pkg::item_t        item,
	output logic                  done,
	output jqd_pkg::result_t      result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	import jqd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > 4) ? CW : 4;
	localparam int SW = (TAG_BITS < 16) ? TAG_BITS : 16;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
			input logic [CW-1:0] offset);
		logic [AW:0] sum;
		sum = (AW+1)'(head) + (AW+1)'(offset);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// control state
	logic [1:0]    disc_q;
	logic [CW-1:0] occ_q;
	logic [AW-1:0] head_q;

	// stage 1
	logic          v_s1;
	op_t           op_s1;
	status_t       st_s1;
	logic [CW-1:0] occ_s1;
	logic [AW-1:0] wa_s1;
	logic [SW-1:0] tag_s1;
	logic          byp_a_s1;
	logic          byp_b_s1;
	logic [SW-1:0] bd_s1;

	// result
	logic    done_q;
	result_t res_q;

	logic          accept;
	logic          cfg_wr;
	logic [AW-1:0] last_slot;
	logic [AW-1:0] tail_slot;
	logic [AW-1:0] pick_slot;
	op_t           op_d;
	status_t       st_d;
	logic [CW-1:0] occ_d;
	logic [AW-1:0] head_d;
	logic [AW-1:0] ra_d;
	logic [AW-1:0] wa_d;
	logic [SW-1:0] ram_a;
	logic [SW-1:0] ram_b;
	logic [SW-1:0] rd_a;
	logic [SW-1:0] rd_b;
	logic          we;
	logic [SW-1:0] wd;
	logic          take;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {30'd0, disc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q <= DISC_OLDEST;
		end else if (cfg_wr) begin
			disc_q <= pwdata[1:0];
		end
	end

	assign last_slot = slot_of(head_q, occ_q - CW'(1));
	assign tail_slot = slot_of(head_q, occ_q);
	assign pick_slot = slot_of(head_q, CW'(item.random_index));

	always_comb begin
		op_d   = OP_NONE;
		st_d   = ST_OK;
		occ_d  = occ_q;
		head_d = head_q;
		ra_d   = head_q;
		wa_d   = tail_slot;
		if (item.command == CMD_INSERT) begin
			if (occ_q == CW'(DEPTH)) begin
				st_d = ST_FULL;
			end else begin
				op_d  = OP_INSERT;
				occ_d = occ_q + CW'(1);
			end
		end else if (occ_q == '0) begin
			st_d = ST_EMPTY;
		end else if (disc_q == DISC_NEWEST) begin
			op_d  = OP_TAKE;
			ra_d  = last_slot;
			occ_d = occ_q - CW'(1);
		end else if (disc_q == DISC_RANDOM) begin
			if (IW'(item.random_index) >= IW'(occ_q)) begin
				st_d = ST_RANGE;
			end else begin
				// fill the hole with the last job
				op_d  = OP_SWAP;
				ra_d  = pick_slot;
				wa_d  = pick_slot;
				occ_d = occ_q - CW'(1);
			end
		end else begin
			op_d   = OP_TAKE;
			head_d = slot_of(head_q, CW'(1));
			occ_d  = occ_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			head_q <= '0;
		end else if (accept) begin
			occ_q  <= occ_d;
			head_q <= head_d;
		end
	end

	jqd_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (wa_s1),
		.wdata   (wd),
		.raddr_a (ra_d),
		.rdata_a (ram_a),
		.raddr_b (last_slot),
		.rdata_b (ram_b)
	);

	// forward the write that lands at the same edge as the read
	assign rd_a = byp_a_s1 ? bd_s1 : ram_a;
	assign rd_b = byp_b_s1 ? bd_s1 : ram_b;
	assign we   = v_s1 & ((op_s1 == OP_INSERT) | (op_s1 == OP_SWAP));
	assign wd   = (op_s1 == OP_SWAP) ? rd_b : tag_s1;
	assign take = (op_s1 == OP_TAKE) | (op_s1 == OP_SWAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			op_s1    <= OP_NONE;
			byp_a_s1 <= 1'b0;
			byp_b_s1 <= 1'b0;
		end else begin
			v_s1     <= accept;
			op_s1    <= accept ? op_d : OP_NONE;
			byp_a_s1 <= we & (wa_s1 == ra_d);
			byp_b_s1 <= we & (wa_s1 == last_slot);
		end
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_d;
		occ_s1 <= occ_d;
		wa_s1  <= wa_d;
		tag_s1 <= item.job_tag[SW-1:0];
		bd_s1  <= wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		res_q.tag_out    <= take ? 16'(rd_a) : 16'd0;
		res_q.tag_valid  <= take;
		res_q.status     <= st_s1;
		res_q.fill_count <= 5'(occ_s1);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
